FILE: rtl/chbf_pkg.sv
`timescale 1ns / 1ps

package chbf_pkg;

   // Counter widths of the framer.
   localparam int SIZE_BITS   = 32;
   localparam int OFFSET_BITS = 16;

   localparam logic [SIZE_BITS-1:0]   SIZE_ZERO  = '0;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // Parser phases.
   localparam logic [2:0] PH_SIZE    = 3'd0;
   localparam logic [2:0] PH_DATA    = 3'd1;
   localparam logic [2:0] PH_DATA_CR = 3'd2;
   localparam logic [2:0] PH_DATA_LF = 3'd3;
   localparam logic [2:0] PH_TRAILER = 3'd4;
   localparam logic [2:0] PH_HALT    = 3'd5;

   // Frame status codes.
   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // Characters the framing looks for.
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   // Parser state carried from one word to the next.
   typedef struct packed {
      logic [2:0]             phase;
      logic [SIZE_BITS-1:0]   chunk_remaining;
      logic                   in_extension;
      logic                   saw_cr;
      logic                   line_empty;
      logic [OFFSET_BITS-1:0] byte_offset;
      logic [1:0]             sticky_status;
   } state_type;

   localparam state_type STATE_CLEAR = '{
      phase:           PH_SIZE,
      chunk_remaining: SIZE_ZERO,
      in_extension:    1'b0,
      saw_cr:          1'b0,
      line_empty:      1'b1,
      byte_offset:     '0,
      sticky_status:   ST_BUSY
   };

   // One result word.
   typedef struct packed {
      logic [7:0]             payload_byte;
      logic                   payload_valid;
      logic [1:0]             frame_status;
      logic [OFFSET_BITS-1:0] end_offset;
   } result_type;

   // True for 0-9, a-f and A-F.
   function automatic logic is_hex(input logic [7:0] b);
      return b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
   endfunction

   // Value of a hex digit; only meaningful when is_hex holds.
   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      if (b inside {[8'h30:8'h39]}) begin
         v = b - 8'h30;
      end else if (b inside {[8'h61:8'h66]}) begin
         v = b - 8'h57;
      end else begin
         v = b - 8'h37;
      end
      return v[3:0];
   endfunction

endpackage

FILE: rtl/chbf_step.sv
`timescale 1ns / 1ps

// Next parser state and result word for one body byte.
module chbf_step (
   input  logic [7:0]          data_byte,
   input  logic                message_start,
   input  chbf_pkg::state_type state,
   output chbf_pkg::state_type state_next,
   output chbf_pkg::result_type result
);

   chbf_pkg::state_type cur;
   chbf_pkg::state_type nxt;
   logic                valid;
   logic                fail;
   logic                done;
   logic [chbf_pkg::SIZE_BITS-1:0] rem_dec;

   assign rem_dec = cur.chunk_remaining - chbf_pkg::SIZE_BITS'(1);

   always_comb begin
      cur   = message_start ? chbf_pkg::STATE_CLEAR : state;
      nxt   = cur;
      valid = 1'b0;
      fail  = 1'b0;
      done  = 1'b0;

      if (cur.sticky_status == chbf_pkg::ST_BUSY && cur.phase != chbf_pkg::PH_HALT) begin
         if (cur.byte_offset != chbf_pkg::OFFSET_MAX) begin
            nxt.byte_offset = cur.byte_offset + chbf_pkg::OFFSET_BITS'(1);
         end

         case (cur.phase)
            chbf_pkg::PH_SIZE: begin
               // A pending CR closes the line when LF follows; outside an extension any other byte breaks it.
               if (cur.saw_cr) begin
                  nxt.saw_cr = 1'b0;
                  if (data_byte == chbf_pkg::CHAR_LF) begin
                     done             = 1'b1;
                     nxt.in_extension = 1'b0;
                     nxt.line_empty   = 1'b1;
                     nxt.phase = (cur.chunk_remaining == chbf_pkg::SIZE_ZERO) ?
                                 chbf_pkg::PH_TRAILER : chbf_pkg::PH_DATA;
                  end else if (!cur.in_extension) begin
                     done = 1'b1;
                     fail = 1'b1;
                  end
               end
               if (!done) begin
                  if (data_byte == chbf_pkg::CHAR_CR) begin
                     nxt.saw_cr = 1'b1;
                  end else if (cur.in_extension) begin
                     nxt.in_extension = 1'b1;
                  end else if (data_byte == chbf_pkg::CHAR_SEMI) begin
                     nxt.in_extension = 1'b1;
                  end else if (data_byte == chbf_pkg::CHAR_SPACE ||
                               data_byte == chbf_pkg::CHAR_TAB) begin
                     nxt.in_extension = 1'b0;
                  end else if (!chbf_pkg::is_hex(data_byte) ||
                               cur.chunk_remaining[chbf_pkg::SIZE_BITS-1 -: 4] != 4'd0) begin
                     // Not a digit, or one more digit would overflow the size.
                     fail = 1'b1;
                  end else begin
                     nxt.chunk_remaining = {cur.chunk_remaining[chbf_pkg::SIZE_BITS-5:0],
                                            chbf_pkg::hex_value(data_byte)};
                  end
               end
            end
            chbf_pkg::PH_DATA: begin
               valid               = 1'b1;
               nxt.chunk_remaining = rem_dec;
               if (rem_dec == chbf_pkg::SIZE_ZERO) begin
                  nxt.phase = chbf_pkg::PH_DATA_CR;
               end
            end
            chbf_pkg::PH_DATA_CR: begin
               if (data_byte == chbf_pkg::CHAR_CR) begin
                  nxt.phase = chbf_pkg::PH_DATA_LF;
               end else begin
                  fail = 1'b1;
               end
            end
            chbf_pkg::PH_DATA_LF: begin
               if (data_byte == chbf_pkg::CHAR_LF) begin
                  nxt.phase           = chbf_pkg::PH_SIZE;
                  nxt.chunk_remaining = chbf_pkg::SIZE_ZERO;
                  nxt.in_extension    = 1'b0;
                  nxt.saw_cr          = 1'b0;
                  nxt.line_empty      = 1'b1;
               end else begin
                  fail = 1'b1;
               end
            end
            chbf_pkg::PH_TRAILER: begin
               // Trailer lines are skipped; an empty one ends the body.
               if (cur.saw_cr && data_byte == chbf_pkg::CHAR_LF) begin
                  nxt.saw_cr = 1'b0;
                  if (cur.line_empty) begin
                     nxt.sticky_status = chbf_pkg::ST_DONE;
                     nxt.phase         = chbf_pkg::PH_HALT;
                  end else begin
                     nxt.line_empty = 1'b1;
                  end
               end else begin
                  nxt.saw_cr = (data_byte == chbf_pkg::CHAR_CR);
                  if (cur.saw_cr || data_byte != chbf_pkg::CHAR_CR) begin
                     nxt.line_empty = 1'b0;
                  end
               end
            end
            default: begin
               fail = 1'b1;
            end
         endcase

         if (fail) begin
            nxt.sticky_status = chbf_pkg::ST_BAD;
            nxt.phase         = chbf_pkg::PH_HALT;
         end
      end
   end

   assign state_next           = nxt;
   assign result.payload_byte  = valid ? data_byte : 8'h00;
   assign result.payload_valid = valid;
   assign result.frame_status  = nxt.sticky_status;
   assign result.end_offset    = nxt.byte_offset;

endmodule

FILE: rtl/http_chunked_body_framer_unit.sv
`timescale 1ns / 1ps

// Chunked body framer: takes one body byte per req word and returns one rsp
// word for it, carrying the byte when it is chunk data, the frame status
// (in progress, complete, malformed) and the byte offset since body start.
// req_message_start marks the first byte of a body and clears the parser
// before that byte is taken.
// A word accepted in one cycle is presented on rsp in the next. Throughput is
// one word per cycle while rsp_ready is high or the result register is empty;
// the parser update is a single pass of the size-line, data and trailer logic
// between the state register and the result register.
// The result register parts the two sides: req_ready stays high while the
// result is empty or being taken in the same cycle, so a stalled receiver
// holds back at most one finished word and then stops intake.
// Reset clears the parser to the start of a body and empties the result
// register; the block accepts a word in the first cycle after reset.
module http_chunked_body_framer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_message_start,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_payload_byte,
   output logic                             rsp_payload_valid,
   output logic [1:0]                       rsp_frame_status,
   output logic [chbf_pkg::OFFSET_BITS-1:0] rsp_end_offset
);

   chbf_pkg::state_type  state_ff;
   chbf_pkg::state_type  state_in;
   chbf_pkg::result_type result_ff;
   chbf_pkg::result_type result_in;
   logic                 out_valid_ff;
   logic                 accept;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   chbf_step u_step (
      .data_byte     (req_data_byte),
      .message_start (req_message_start),
      .state         (state_ff),
      .state_next    (state_in),
      .result        (result_in)
   );

   // Parser state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chbf_pkg::STATE_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Result word.
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_byte  = result_ff.payload_byte;
   assign rsp_payload_valid = result_ff.payload_valid;
   assign rsp_frame_status  = result_ff.frame_status;
   assign rsp_end_offset    = result_ff.end_offset;

endmodule
